FILE: src/vsd_pkg.sv
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants of the velocity shift deposit block
// Opcodes, register indexes, saturation limits and the command and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int MAX_EXTENT_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;

    localparam logic OP_DEPOSIT = 1'b0;
    localparam logic OP_READ    = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_WHOLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_FRACTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT_AXIS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z         = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;

    localparam logic [4:0] SIZE_RESET = 5'd16;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the accepted item
        logic mul;       // form the rounded low part
        logic rd0;       // read the first target cell
        logic rd1;       // read the second target cell
        logic wr_acc0;   // write first cell plus low part
        logic wr_acc1;   // write second cell plus high part
        logic wr_zero;   // clear the cell that was read
        logic clr;       // clearing pass after reset
        logic out_load;  // load the result register
    } vsd_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic op_read;
        logic frac_nz;
        logic clr_last;
        logic out_free;
    } vsd_sts_t;

endpackage

FILE: src/velocity_shift_deposit.sv
// ----------------------------------------------------------------------------
// velocity_shift_deposit: shifted deposit accumulator over a velocity grid
// Deposits a cell value split by a fractional shift into one or two grid cells
// along one axis, with clamped coordinates and saturating sums; a read item
// returns one accumulated cell and clears it.
//
//   channel  direction  ports                          item
//   s_       in         s_tvalid s_tready s_tdata      deposit or read
//                       s_tuser
//   m_       out        m_tvalid m_tready m_tdata      accumulated cell
//   cfg_     in         cfg_valid cfg_ready cfg_index  register write
//                       cfg_data
//
// A deposit runs a multiply step, then a read-modify-write of its first target
// cell and, with a nonzero fraction, of its second, one cell update per cycle on
// the single grid memory; a read runs the multiply step, then loads the result.
// After reset all 2**(3*clog2(MAX_EXTENT)) grid cells (4096 at the default) are
// cleared one cell a cycle, while s_tready stays low.
// A stalled result holds in the output register; a deposit still proceeds
// behind it, and a read waits until the register frees up.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module velocity_shift_deposit
    import vsd_pkg::*;
#(
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coord_x [3:0], coord_y [7:4], coord_z [11:8], cell_value [43:12]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // opcode [0]
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // read_value [31:0], saturation_seen [32]
    output logic [M_TDATA_W-1:0]   m_tdata
);

    vsd_cmd_t cmd;
    vsd_sts_t sts;

    assign cfg_ready = 1'b1;

    vsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vsd_datapath #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: src/vsd_ctrl.sv
// ----------------------------------------------------------------------------
// vsd_ctrl: sequencing of one item at a time
// Runs the clearing pass after reset, then steps each item through the
// multiply, the read-modify-write updates of the grid and the result load.
// ----------------------------------------------------------------------------
module vsd_ctrl
    import vsd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  vsd_sts_t sts,
    output vsd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ACC0,
        S_ACC1,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                cmd.rd0    = 1'b1;
                state_next = sts.op_read ? S_READ : S_ACC0;
            end
            S_ACC0: begin
                cmd.wr_acc0 = 1'b1;
                cmd.rd1     = sts.frac_nz;
                state_next  = sts.frac_nz ? S_ACC1 : S_IDLE;
            end
            S_ACC1: begin
                cmd.wr_acc1 = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ: begin
                // The read data stays in the memory output register until
                // the result register frees up.
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.wr_zero  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_MUL))
        else $error("accepted item did not start its multiply step");

    a_mul_branch: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MUL) |=> (state_reg == S_ACC0 || state_reg == S_READ))
        else $error("multiply step not followed by an update or a read");

    a_second_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC1) |-> sts.frac_nz)
        else $error("second update with a zero fraction");

endmodule

FILE: src/vsd_datapath.sv
// ----------------------------------------------------------------------------
// vsd_datapath: configuration, item registers, split multiply and grid
// Holds the shift and size registers, forms the rounded low and high parts
// of a deposit, clamps target coordinates and accumulates into the grid
// memory with saturation.
// ----------------------------------------------------------------------------
module vsd_datapath
    import vsd_pkg::*;
#(
    parameter int MAX_EXTENT = MAX_EXTENT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  vsd_cmd_t               cmd,
    output vsd_sts_t               sts
);

    localparam int CW    = $clog2(MAX_EXTENT);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;

    // Configuration registers.
    logic [4:0]  shift_whole_reg;
    logic [15:0] shift_fraction_reg;
    logic [1:0]  shift_axis_reg;
    logic [4:0]  size_x_reg;
    logic [4:0]  size_y_reg;
    logic [4:0]  size_z_reg;

    // Item registers.
    logic               op_reg;
    logic [3:0]         x_reg;
    logic [3:0]         y_reg;
    logic [3:0]         z_reg;
    logic signed [31:0] value_reg;

    logic signed [31:0] low_reg;
    logic signed [31:0] high_reg;
    logic [31:0]        acc0_reg;
    logic               sat_flag_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic               out_valid_reg;
    logic [31:0]        out_value_reg;
    logic               out_sat_reg;

    logic [31:0]   grid_mem [DEPTH];
    logic [31:0]   mem_rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [AW-1:0] addr0;
    logic [AW-1:0] addr1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_whole_reg    <= '0;
            shift_fraction_reg <= '0;
            shift_axis_reg     <= AXIS_X;
            size_x_reg         <= SIZE_RESET;
            size_y_reg         <= SIZE_RESET;
            size_z_reg         <= SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SHIFT_WHOLE:    shift_whole_reg    <= cfg_data[4:0];
                REG_SHIFT_FRACTION: shift_fraction_reg <= cfg_data[15:0];
                REG_SHIFT_AXIS:     shift_axis_reg     <= cfg_data[1:0];
                REG_SIZE_X:         size_x_reg         <= cfg_data[4:0];
                REG_SIZE_Y:         size_y_reg         <= cfg_data[4:0];
                REG_SIZE_Z:         size_z_reg         <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_tuser[0];
            x_reg     <= s_tdata[3:0];
            y_reg     <= s_tdata[7:4];
            z_reg     <= s_tdata[11:8];
            value_reg <= $signed(s_tdata[43:12]);
        end
    end

    // Low part: floor((v * (65536 - f) + 32768) / 65536), one registered
    // multiply-add.
    logic [16:0]        mult_c;
    logic signed [49:0] prod_c;
    logic signed [49:0] round_c;

    assign mult_c  = 17'h1_0000 - {1'b0, shift_fraction_reg};
    assign prod_c  = value_reg * $signed({1'b0, mult_c});
    assign round_c = prod_c + 50'sd32768;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            low_reg <= $signed(round_c[47:16]);
        end
        if (cmd.wr_acc0) begin
            high_reg <= value_reg - low_reg;
        end
    end

    // Target coordinates.
    function automatic logic [CW-1:0] clamp_coord(input logic signed [7:0] t,
                                                  input logic [4:0] size);
        logic [7:0]        eff;
        logic signed [7:0] hi;
        logic signed [7:0] r;
        if (size == 5'd0) begin
            eff = 8'd1;
        end else if ({3'b000, size} > 8'(MAX_EXTENT)) begin
            eff = 8'(MAX_EXTENT);
        end else begin
            eff = {3'b000, size};
        end
        hi = $signed(eff - 8'd1);
        if (t < 0) begin
            r = 8'sd0;
        end else if (t > hi) begin
            r = hi;
        end else begin
            r = t;
        end
        return r[CW-1:0];
    endfunction

    logic              on_x;
    logic              on_y;
    logic              on_z;
    logic signed [7:0] whole_c;
    logic signed [7:0] off0_c;
    logic signed [7:0] off1_c;
    logic signed [7:0] bx_c;
    logic signed [7:0] by_c;
    logic signed [7:0] bz_c;

    always_comb begin
        on_x = 1'b0;
        on_y = 1'b0;
        on_z = 1'b0;
        unique case (shift_axis_reg)
            AXIS_X:  on_x = 1'b1;
            AXIS_Y:  on_y = 1'b1;
            default: on_z = 1'b1;
        endcase
    end

    assign whole_c = {{3{shift_whole_reg[4]}}, shift_whole_reg};
    // A read looks at the cell itself, without any shift.
    assign off0_c  = (op_reg == OP_READ) ? 8'sd0 : whole_c;
    assign off1_c  = whole_c + 8'sd1;
    assign bx_c    = $signed({4'b0000, x_reg});
    assign by_c    = $signed({4'b0000, y_reg});
    assign bz_c    = $signed({4'b0000, z_reg});

    assign addr0 = {clamp_coord(on_x ? bx_c + off0_c : bx_c, size_x_reg),
                    clamp_coord(on_y ? by_c + off0_c : by_c, size_y_reg),
                    clamp_coord(on_z ? bz_c + off0_c : bz_c, size_z_reg)};
    assign addr1 = {clamp_coord(on_x ? bx_c + off1_c : bx_c, size_x_reg),
                    clamp_coord(on_y ? by_c + off1_c : by_c, size_y_reg),
                    clamp_coord(on_z ? bz_c + off1_c : bz_c, size_z_reg)};

    // Saturating accumulation. When both targets clamp to the same cell the
    // second update takes the value written by the first.
    logic [31:0] base1_c;
    logic [32:0] sum0_c;
    logic [32:0] sum1_c;
    logic        sat0_c;
    logic        sat1_c;
    logic [31:0] res0_c;
    logic [31:0] res1_c;

    assign base1_c = (addr1 == addr0) ? acc0_reg : mem_rdata_reg;
    assign sum0_c  = {mem_rdata_reg[31], mem_rdata_reg} + {low_reg[31], low_reg};
    assign sum1_c  = {base1_c[31], base1_c} + {high_reg[31], high_reg};
    assign sat0_c  = sum0_c[32] ^ sum0_c[31];
    assign sat1_c  = sum1_c[32] ^ sum1_c[31];
    assign res0_c  = sat0_c ? (sum0_c[32] ? SAT_MIN : SAT_MAX) : sum0_c[31:0];
    assign res1_c  = sat1_c ? (sum1_c[32] ? SAT_MIN : SAT_MAX) : sum1_c[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.wr_acc0) begin
            acc0_reg <= res0_c;
        end
    end

    // Grid memory: one write and one read port, read data registered.
    assign mem_we    = cmd.wr_acc0 | cmd.wr_acc1 | cmd.wr_zero | cmd.clr;
    assign mem_waddr = cmd.clr ? clr_cnt_reg : (cmd.wr_acc1 ? addr1 : addr0);
    assign mem_wdata = cmd.wr_acc0 ? res0_c : (cmd.wr_acc1 ? res1_c : 32'd0);
    assign mem_raddr = cmd.rd1 ? addr1 : addr0;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd0 || cmd.rd1) begin
            mem_rdata_reg <= grid_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg   <= '0;
            sat_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if ((cmd.wr_acc0 && sat0_c) || (cmd.wr_acc1 && sat1_c)) begin
                sat_flag_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= mem_rdata_reg;
            out_sat_reg   <= sat_flag_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_sat_reg, out_value_reg};

    assign sts.op_read  = (op_reg == OP_READ);
    assign sts.frac_nz  = (shift_fraction_reg != 16'd0);
    assign sts.clr_last = &clr_cnt_reg;
    assign sts.out_free = !out_valid_reg || m_tready;

    a_acc1_after_acc0: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_acc1 |-> $past(cmd.wr_acc0))
        else $error("second update without a first update before it");

    a_sat_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_flag_reg |=> sat_flag_reg)
        else $error("saturation flag cleared after being set");

    a_clear_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.clr && sts.clr_last) |=> !cmd.clr)
        else $error("clearing pass ran past the last cell");

endmodule

FILE: test/tb_velocity_shift_deposit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_velocity_shift_deposit: self-checking bench of the shifted deposit block
// A queue of pending items and register writes feeds a clocked driver; a
// clocked monitor compares every read result against a grid model that the
// driver updates as items are taken. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_velocity_shift_deposit;
    import vsd_pkg::*;

    localparam int IDLE_PCT      = 30;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int GRID_CELLS    = MAX_EXTENT_DEF * MAX_EXTENT_DEF * MAX_EXTENT_DEF;

    localparam logic [1:0] AXIS_Z       = 2'd2;
    localparam logic [1:0] AXIS_Z_ALIAS = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {ENT_ITEM, ENT_CFG, ENT_DRAIN} entry_kind_t;

    typedef struct {
        entry_kind_t             kind;
        logic                    op;
        logic [3:0]              x;
        logic [3:0]              y;
        logic [3:0]              z;
        logic [31:0]             value;
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0]   data;
    } entry_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } reading_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    entry_t   stimulus[$];
    reading_t pending_reads[$];

    // Grid model and its register copies.
    int                 grid [GRID_CELLS];
    logic               sat_sticky = 1'b0;
    logic signed [4:0]  shift_cells = 5'sd0;
    logic [15:0]        frac_q16 = 16'd0;
    logic [1:0]         axis_sel = AXIS_X;
    logic [4:0]         span_x = SIZE_RESET;
    logic [4:0]         span_y = SIZE_RESET;
    logic [4:0]         span_z = SIZE_RESET;

    int items_taken  = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int cycles       = 0;

    velocity_shift_deposit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Grid model
    // ------------------------------------------------------------------
    function automatic int cells_in_use(logic [4:0] span);
        if (span == 5'd0) return 1;
        if (span > MAX_EXTENT_DEF) return MAX_EXTENT_DEF;
        return int'(span);
    endfunction

    function automatic int clamp_index(int c, logic [4:0] span);
        int top;
        top = cells_in_use(span) - 1;
        if (c < 0) return 0;
        if (c > top) return top;
        return c;
    endfunction

    function automatic int grid_addr(int x, int y, int z);
        return (clamp_index(x, span_x) * MAX_EXTENT_DEF + clamp_index(y, span_y))
               * MAX_EXTENT_DEF + clamp_index(z, span_z);
    endfunction

    task automatic add_into(int addr, longint part);
        longint total;
        total = longint'(grid[addr]) + part;
        if (total > SUM_MAX) begin
            total = SUM_MAX;
            sat_sticky = 1'b1;
        end
        if (total < SUM_MIN) begin
            total = SUM_MIN;
            sat_sticky = 1'b1;
        end
        grid[addr] = int'(total);
    endtask

    task automatic deposit_part(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                int offset, longint part);
        int tx;
        int ty;
        int tz;
        tx = int'(x);
        ty = int'(y);
        tz = int'(z);
        // Axis code three falls through to z.
        if (axis_sel == AXIS_X) tx += offset;
        else if (axis_sel == AXIS_Y) ty += offset;
        else tz += offset;
        add_into(grid_addr(tx, ty, tz), part);
    endtask

    task automatic account_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                                logic [31:0] value);
        int     addr;
        longint v;
        longint p;
        longint low_part;
        reading_t r;
        if (op == OP_READ) begin
            addr = grid_addr(int'(x), int'(y), int'(z));
            r.value = grid[addr];
            r.sat = sat_sticky;
            pending_reads.insert(pending_reads.size(), r);
            grid[addr] = 0;
        end else begin
            v = longint'($signed(value));
            p = v * (64'sd65536 - longint'(frac_q16));
            // Round half up: floor of the scaled product plus one half.
            low_part = (p + 64'sd32768) >>> 16;
            deposit_part(x, y, z, int'(shift_cells), low_part);
            if (frac_q16 != 16'd0)
                deposit_part(x, y, z, int'(shift_cells) + 1, v - low_part);
        end
    endtask

    task automatic apply_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SHIFT_WHOLE:    shift_cells = data[4:0];
            REG_SHIFT_FRACTION: frac_q16 = data;
            REG_SHIFT_AXIS:     axis_sel = data[1:0];
            REG_SIZE_X:         span_x = data[4:0];
            REG_SIZE_Y:         span_y = data[4:0];
            REG_SIZE_Z:         span_z = data[4:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic entry_t blank_entry(entry_kind_t kind);
        entry_t e;
        e.kind    = kind;
        e.op      = OP_DEPOSIT;
        e.x       = '0;
        e.y       = '0;
        e.z       = '0;
        e.value   = '0;
        e.reg_idx = '0;
        e.data    = '0;
        return e;
    endfunction

    task automatic add_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
                            logic [31:0] value);
        entry_t e;
        e = blank_entry(ENT_ITEM);
        e.op    = op;
        e.x     = x;
        e.y     = y;
        e.z     = z;
        e.value = value;
        stimulus.insert(stimulus.size(), e);
    endtask

    task automatic add_setting(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        entry_t e;
        e = blank_entry(ENT_CFG);
        e.reg_idx = idx;
        e.data    = data;
        stimulus.insert(stimulus.size(), e);
    endtask

    // Unused upper bits of a narrow register get random content now and then.
    function automatic logic [15:0] with_noise(logic [15:0] v, int width);
        logic [15:0] noise;
        noise = 16'($urandom) & ~((16'd1 << width) - 16'd1);
        if ($urandom_range(3) == 0) return v | noise;
        return v;
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_phase(logic [4:0] whole, logic [15:0] frac, logic [1:0] axis,
                             logic [4:0] sx, logic [4:0] sy, logic [4:0] sz,
                             int count, bit drain_mid);
        logic [3:0] hot_x;
        logic [3:0] hot_y;
        logic [3:0] hot_z;
        logic       op;
        hot_x = $urandom;
        hot_y = $urandom;
        hot_z = $urandom;
        add_setting(REG_SHIFT_WHOLE, with_noise({11'd0, whole}, 5));
        add_setting(REG_SHIFT_FRACTION, frac);
        add_setting(REG_SHIFT_AXIS, with_noise({14'd0, axis}, 2));
        add_setting(REG_SIZE_X, with_noise({11'd0, sx}, 5));
        add_setting(REG_SIZE_Y, with_noise({11'd0, sy}, 5));
        add_setting(REG_SIZE_Z, with_noise({11'd0, sz}, 5));
        for (int i = 0; i < count; i++) begin
            if (drain_mid && i == count / 2)
                stimulus.insert(stimulus.size(), blank_entry(ENT_DRAIN));
            op = ($urandom_range(99) < 35) ? OP_READ : OP_DEPOSIT;
            // Most items land near one hot spot so that reads find accumulated cells.
            if ($urandom_range(9) < 7)
                add_item(op, hot_x + 4'($urandom_range(3)), hot_y + 4'($urandom_range(3)),
                         hot_z + 4'($urandom_range(3)), random_value());
            else
                add_item(op, 4'($urandom), 4'($urandom), 4'($urandom), random_value());
        end
    endtask

    function automatic logic calm_stretch();
        return items_taken >= 400 && items_taken < 520;
    endfunction

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : feed_block
        logic   next_s_valid;
        logic   next_cfg_valid;
        logic   block_idle;
        entry_t head;
        if (!aresetn) begin
            s_tvalid     <= 1'b0;
            cfg_valid    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            next_s_valid   = s_tvalid && !s_tready;
            next_cfg_valid = cfg_valid && !cfg_ready;
            if (s_tvalid && s_tready) begin
                account_item(s_tuser[0], s_tdata[3:0], s_tdata[7:4], s_tdata[11:8],
                             s_tdata[43:12]);
                items_taken <= items_taken + 1;
            end
            if (cfg_valid && cfg_ready) apply_setting(cfg_index, cfg_data);
            if (s_tvalid || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;

            // Deposits give no result, so wait out their cycles before calling the block idle.
            block_idle = pending_reads.size() == 0 && quiet_cycles >= SETTLE_CYCLES
                         && !s_tvalid;
            if (!next_s_valid && !next_cfg_valid && stimulus.size() != 0) begin
                head = stimulus[0];
                case (head.kind)
                    ENT_ITEM: begin
                        if (calm_stretch() || $urandom_range(99) >= IDLE_PCT) begin
                            head = stimulus.pop_front();
                            next_s_valid = 1'b1;
                            s_tdata <= {4'd0, head.value, head.z, head.y, head.x};
                            s_tuser <= head.op;
                        end
                    end
                    ENT_CFG: begin
                        if (block_idle) begin
                            head = stimulus.pop_front();
                            next_cfg_valid = 1'b1;
                            cfg_index <= head.reg_idx;
                            cfg_data  <= head.data;
                        end
                    end
                    default: begin
                        if (block_idle) head = stimulus.pop_front();
                    end
                endcase
            end
            s_tvalid  <= next_s_valid;
            cfg_valid <= next_cfg_valid;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : watch_block
        reading_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_reads.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: read_value %h saturation_seen %b",
                                 m_tdata[31:0], m_tdata[32]);
                end else begin
                    want = pending_reads.pop_front();
                    if (m_tdata[31:0] !== want.value || m_tdata[32] !== want.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: read_value exp %h got %h, %s%b got %b",
                                     want.value, m_tdata[31:0], "saturation_seen exp ",
                                     want.sat, m_tdata[32]);
                    end
                end
            end
            m_tready <= calm_stretch() || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < GRID_CELLS; i++) grid[i] = 0;

        // Reset settings: no shift, full grid.
        add_item(OP_DEPOSIT, 4'd0, 4'd0, 4'd0, 32'h7FFF_FFFF);
        add_item(OP_READ, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF);
        add_item(OP_DEPOSIT, 4'd15, 4'd15, 4'd15, 32'h8000_0000);
        add_item(OP_READ, 4'd15, 4'd15, 4'd15, 32'h0000_0000);
        add_item(OP_DEPOSIT, 4'd5, 4'd6, 4'd7, 32'h0001_8000);
        add_item(OP_DEPOSIT, 4'd5, 4'd6, 4'd7, 32'hFFFF_0000);
        add_item(OP_READ, 4'd5, 4'd6, 4'd7, 32'h5555_AAAA);
        add_item(OP_READ, 4'd5, 4'd6, 4'd7, 32'h0000_0000);
        add_item(OP_DEPOSIT, 4'd10, 4'd5, 4'd10, 32'h0000_0001);
        add_item(OP_READ, 4'd10, 4'd5, 4'd10, 32'h0000_0000);
        // Positive saturation into one cell, then negative saturation into another.
        add_item(OP_DEPOSIT, 4'd3, 4'd3, 4'd3, 32'h7FFF_FFFF);
        add_item(OP_DEPOSIT, 4'd3, 4'd3, 4'd3, 32'h7FFF_FFFF);
        add_item(OP_READ, 4'd3, 4'd3, 4'd3, 32'h0000_0000);
        add_item(OP_DEPOSIT, 4'd9, 4'd9, 4'd9, 32'h8000_0000);
        add_item(OP_DEPOSIT, 4'd9, 4'd9, 4'd9, 32'h8000_0000);
        add_item(OP_READ, 4'd9, 4'd9, 4'd9, 32'h0000_0000);

        // Largest forward shift with the largest fraction; targets clamp at the edge.
        add_phase(5'd15, 16'hFFFF, AXIS_X, 5'd16, 5'd16, 5'd16, 60, 1'b1);
        // Spare register indexes must not disturb anything.
        add_setting(REG_SPARE_LO, 16'hFFFF);
        add_setting(REG_SPARE_HI, 16'h1234);
        // Shift of minus sixteen, smallest fraction, axis alias, zero sizes (one cell).
        add_phase(5'h10, 16'h0001, AXIS_Z_ALIAS, 5'd0, 5'd0, 5'd0, 50, 1'b0);
        // Half-cell backward shift along y, oversized and unit sizes.
        add_phase(5'h1F, 16'h8000, AXIS_Y, 5'd31, 5'd17, 5'd1, 60, 1'b0);
        add_phase(5'd0, 16'h0000, AXIS_Z, 5'd4, 5'd4, 5'd4, 30, 1'b0);

        for (int ph = 0; ph < 8; ph++)
            add_phase(5'($urandom), ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom),
                      2'($urandom), 5'($urandom_range(31)), 5'($urandom_range(31)),
                      5'($urandom_range(31)), 80, ph % 3 == 1);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (stimulus.size() != 0 || s_tvalid || cfg_valid) @(posedge aclk);
        while (pending_reads.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/vsd_pkg.sv
src/vsd_ctrl.sv
src/vsd_datapath.sv
src/velocity_shift_deposit.sv
test/tb_velocity_shift_deposit.sv
